FILE: rtl/tpps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpps_pkg;

  localparam int MAX_SLOTS_DEF = 16;
  localparam int TIME_W        = 21;
  localparam logic [TIME_W-1:0] WAIT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  slot;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    logic [7:0]  priority_order;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] tick_time;
    logic              idle;
    logic [3:0]        run_slot;
    logic              finished;
    logic [TIME_W-1:0] response_time;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] turnaround_time;
    logic              all_done;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic take;       // request accepted this edge
    logic scan_init;  // tick request: clear best candidate
    logic rd_en;      // issue table read for the scan
    logic finalize;   // commit chosen slot and emit result
  } ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/tpps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tpps_ctrl
  import tpps_pkg::*;
#(
  parameter int SLOT_W = 4,
  parameter int CNT_W  = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire cmd_e              cmd_i,
  input  wire logic [CNT_W-1:0]  act_cnt_i,
  output logic                   busy_o,
  output ctrl_cmd_t              cmd_o,
  output logic [SLOT_W-1:0]      rd_idx_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_FINAL = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic              take;
  logic              last;

  assign take = start_i && (state_q == ST_IDLE);
  assign last = (CNT_W'(idx_q) + CNT_W'(1)) == act_cnt_i;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take && cmd_i == CMD_TICK) begin
          idx_d   = '0;
          state_d = (act_cnt_i == '0) ? ST_FINAL : ST_SCAN;
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + SLOT_W'(1);
        if (last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_d = ST_FINAL;
      end
      ST_FINAL: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign rd_idx_o        = idx_q;
  assign cmd_o.take      = take;
  assign cmd_o.scan_init = take && (cmd_i == CMD_TICK);
  assign cmd_o.rd_en     = (state_q == ST_SCAN);
  assign cmd_o.finalize  = (state_q == ST_FINAL);

endmodule

`default_nettype wire

FILE: rtl/tpps_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module tpps_dpath
  import tpps_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int SLOT_W    = $clog2(MAX_SLOTS),
  parameter int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctrl_cmd_t         cmd_i,
  input  wire logic [SLOT_W-1:0] rd_idx_i,
  input  wire item_t             item_i,
  input  wire logic              cfg_we_i,
  input  wire logic [4:0]        cfg_wdata_i,
  output logic [CNT_W-1:0]       act_cnt_o,
  output result_t                result_o,
  output logic                   result_valid_o
);

  typedef struct packed {
    logic [15:0]       arrival;
    logic [15:0]       burst;
    logic [7:0]        order;
    logic [15:0]       remaining;
    logic [TIME_W-1:0] wait_cnt;
    logic [TIME_W-1:0] response;
  } rec_t;

  // slot table
  rec_t mem [MAX_SLOTS];
  rec_t rd_q;

  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  rec_t              mem_wdata;

  logic [MAX_SLOTS-1:0] done_q, done_d;
  logic [MAX_SLOTS-1:0] act_mask;
  logic [4:0]           cnt_q;
  logic [TIME_W-1:0]    now_q;

  logic              pipe_vld_q;
  logic [SLOT_W-1:0] pipe_idx_q;

  logic              found_q;
  rec_t              best_q;      // wait_cnt holds the value before this tick
  logic [SLOT_W-1:0] best_idx_q;

  result_t res_q;
  logic    res_vld_q;

  logic                ready;
  logic                better;
  logic [TIME_W-1:0]   wait_inc;
  logic                first_run;
  logic [TIME_W-1:0]   resp_new;
  logic [15:0]         rem_new;
  logic                fin;
  logic [TIME_W-1:0]   turn;
  logic                ld_ok;
  logic [SLOT_W+3:0]   slot_ext;
  logic [SLOT_W-1:0]   ld_idx;
  logic                all_done;

  assign act_cnt_o = (32'(cnt_q) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(cnt_q);

  // scan stage
  assign ready    = pipe_vld_q && !done_q[pipe_idx_q] &&
                    ({5'd0, rd_q.arrival} <= now_q);
  assign better   = ready && (!found_q || rd_q.order < best_q.order);
  assign wait_inc = (rd_q.wait_cnt == WAIT_MAX) ? rd_q.wait_cnt
                                                : rd_q.wait_cnt + TIME_W'(1);

  // commit of chosen slot
  assign first_run = (best_q.remaining == best_q.burst);
  assign resp_new  = first_run ? (now_q - {5'd0, best_q.arrival}) : best_q.response;
  assign rem_new   = best_q.remaining - 16'd1;
  assign fin       = found_q && (rem_new == 16'd0);
  assign turn      = now_q + TIME_W'(1) - {5'd0, best_q.arrival};

  // load request
  assign slot_ext = (SLOT_W + 4)'(item_i.slot);
  assign ld_idx   = slot_ext[SLOT_W-1:0];
  assign ld_ok    = cmd_i.take && (item_i.cmd == CMD_LOAD) &&
                    (32'(item_i.slot) < MAX_SLOTS);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ld_idx;
    mem_wdata = rd_q;
    if (cmd_i.finalize && found_q) begin
      mem_we              = 1'b1;
      mem_waddr           = best_idx_q;
      mem_wdata           = best_q;
      mem_wdata.remaining = rem_new;
      mem_wdata.response  = resp_new;
    end else if (ready) begin
      // every ready slot gains a wait unit; the chosen one is restored at commit
      mem_we             = 1'b1;
      mem_waddr          = pipe_idx_q;
      mem_wdata          = rd_q;
      mem_wdata.wait_cnt = wait_inc;
    end else if (ld_ok) begin
      mem_we              = 1'b1;
      mem_waddr           = ld_idx;
      mem_wdata.arrival   = item_i.arrival_time;
      mem_wdata.burst     = item_i.burst_time;
      mem_wdata.order     = item_i.priority_order;
      mem_wdata.remaining = item_i.burst_time;
      mem_wdata.wait_cnt  = '0;
      mem_wdata.response  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_idx_i];
    end
  end

  always_comb begin
    done_d = done_q;
    if (ld_ok) begin
      done_d[ld_idx] = (item_i.burst_time == 16'd0);
    end
    if (cmd_i.finalize && fin) begin
      done_d[best_idx_q] = 1'b1;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_SLOTS; k++) begin
      act_mask[k] = (CNT_W'(k) < act_cnt_o);
    end
  end

  assign all_done = &(done_d | ~act_mask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q     <= '1;
      cnt_q      <= 5'd1;
      now_q      <= '0;
      pipe_vld_q <= 1'b0;
      found_q    <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      done_q     <= done_d;
      pipe_vld_q <= cmd_i.rd_en;
      res_vld_q  <= cmd_i.finalize;
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
      if (cmd_i.take && item_i.cmd == CMD_CLEAR) begin
        now_q <= '0;
      end else if (cmd_i.finalize) begin
        now_q <= now_q + TIME_W'(1);
      end
      if (cmd_i.scan_init) begin
        found_q <= 1'b0;
      end else if (better) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_idx_q <= rd_idx_i;
    if (better) begin
      best_q     <= rd_q;
      best_idx_q <= pipe_idx_q;
    end
    if (cmd_i.finalize) begin
      res_q.tick_time       <= now_q;
      res_q.idle            <= !found_q;
      res_q.run_slot        <= found_q ? 4'(best_idx_q) : 4'd0;
      res_q.finished        <= fin;
      res_q.response_time   <= fin ? resp_new : '0;
      res_q.waiting_time    <= fin ? best_q.wait_cnt : '0;
      res_q.turnaround_time <= fin ? turn : '0;
      res_q.all_done        <= all_done;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_vld_q;

endmodule

`default_nettype wire

FILE: rtl/tick_priority_process_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none

// Preemptive priority scheduler over a table of process slots.
// Requests: item_i is taken at a clock edge with start_i high and busy_o low.
//   Load and clear-clock requests complete at that edge; busy_o stays low and
//   they produce no result.
//   A tick request scans the active slots one per cycle through the slot
//   table read port, then commits the chosen slot. busy_o stays high through
//   the scan, a wait state and the commit (only the commit when no slot is
//   active); the result appears on result_o with result_valid_o high for one
//   cycle right after busy_o falls, and no new request is taken while busy_o
//   is high.
// Results cannot be held off: the strobe lasts one cycle, and the next
//   request may be taken in that same cycle.
// Configuration: cfg_we_i writes the active slot count from cfg_wdata_i;
//   write it only while busy_o is low and no result is pending.
// Reset: clock cleared, every slot marked finished, slot count set to 1.
//   Slot contents are undefined until loaded.
module tick_priority_process_scheduler
  import tpps_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire item_t      item_i,
  input  wire logic       cfg_we_i,
  input  wire logic [4:0] cfg_wdata_i,
  output result_t         result_o,
  output logic            result_valid_o
);

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

  ctrl_cmd_t         ctrl_cmd;
  logic [SLOT_W-1:0] rd_idx;
  logic [CNT_W-1:0]  act_cnt;

  tpps_ctrl #(
    .SLOT_W (SLOT_W),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .cmd_i     (item_i.cmd),
    .act_cnt_i (act_cnt),
    .busy_o    (busy_o),
    .cmd_o     (ctrl_cmd),
    .rd_idx_o  (rd_idx)
  );

  tpps_dpath #(
    .MAX_SLOTS (MAX_SLOTS),
    .SLOT_W    (SLOT_W),
    .CNT_W     (CNT_W)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .rd_idx_i       (rd_idx),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .act_cnt_o      (act_cnt),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tpps_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RAND_REQS = 1450;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct {
    bit          is_cfg;
    logic [4:0]  cfg_val;
    item_t       req;
    bit          pinned;
    result_t     want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  item_t       item_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        busy_o;
  result_t     result_o;
  logic        result_valid_o;

  // typed-in expectation that travels alongside the request being offered
  bit          pin_on = 1'b0;
  result_t     pin_res = '0;

  // scheduler shadow state
  logic [20:0] sim_clock = '0;
  logic [4:0]  slot_count = 5'd1;
  logic [15:0] arr_q   [MAX_SLOTS_DEF];
  logic [15:0] burst_q [MAX_SLOTS_DEF];
  logic [15:0] rem_q   [MAX_SLOTS_DEF];
  logic [7:0]  ord_q   [MAX_SLOTS_DEF];
  logic [20:0] wait_q  [MAX_SLOTS_DEF];
  logic [20:0] resp_q  [MAX_SLOTS_DEF];
  bit          done_q  [MAX_SLOTS_DEF] = '{default: 1'b1};

  result_t     due_results[$];
  row_t        dir_tab[$];
  int          errors = 0;
  int          quiet_cycles = 0;
  int          sent = 0;
  int          burst_left = 0;

  tick_priority_process_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic item_t mk_req(cmd_e c, logic [3:0] s, logic [15:0] a,
                                   logic [15:0] b, logic [7:0] o);
    item_t r;
    r.cmd = c;
    r.slot = s;
    r.arrival_time = a;
    r.burst_time = b;
    r.priority_order = o;
    return r;
  endfunction

  // short process near the start of the clock, orders often colliding
  function automatic item_t fresh_proc(logic [3:0] s);
    logic [15:0] b;
    logic [7:0]  o;
    b = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
    o = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
    return mk_req(CMD_LOAD, s, 16'($urandom_range(0, 24)), b, o);
  endfunction

  task automatic sched_step(input item_t it, output bit emits, output result_t r);
    int  n;
    int  pick;
    bit  found;
    logic [20:0] now;
    n = (slot_count > 5'd16) ? 16 : int'(slot_count);
    emits = 1'b0;
    r = '0;
    case (it.cmd)
      CMD_LOAD: begin
        arr_q[it.slot] = it.arrival_time;
        burst_q[it.slot] = it.burst_time;
        ord_q[it.slot] = it.priority_order;
        rem_q[it.slot] = it.burst_time;
        wait_q[it.slot] = '0;
        resp_q[it.slot] = '0;
        done_q[it.slot] = (it.burst_time == 16'd0);
      end
      CMD_CLEAR: sim_clock = '0;
      CMD_TICK: begin
        emits = 1'b1;
        now = sim_clock;
        found = 1'b0;
        pick = 0;
        for (int k = 0; k < n; k++) begin
          if (!done_q[k] && {5'd0, arr_q[k]} <= now && (!found || ord_q[k] < ord_q[pick])) begin
            pick = k;
            found = 1'b1;
          end
        end
        r.idle = !found;
        if (found) begin
          r.run_slot = 4'(pick);
          // first run of this process
          if (rem_q[pick] == burst_q[pick]) resp_q[pick] = now - {5'd0, arr_q[pick]};
          rem_q[pick] = rem_q[pick] - 16'd1;
          if (rem_q[pick] == 16'd0) begin
            done_q[pick] = 1'b1;
            r.finished = 1'b1;
            r.turnaround_time = now + 21'd1 - {5'd0, arr_q[pick]};
          end
          for (int k = 0; k < n; k++) begin
            if (k != pick && !done_q[k] && {5'd0, arr_q[k]} <= now && wait_q[k] != WAIT_MAX)
              wait_q[k] = wait_q[k] + 21'd1;
          end
          if (r.finished) begin
            r.response_time = resp_q[pick];
            r.waiting_time = wait_q[pick];
          end
        end
        r.all_done = 1'b1;
        for (int k = 0; k < n; k++) if (!done_q[k]) r.all_done = 1'b0;
        r.tick_time = now;
        sim_clock = now + 21'd1;
      end
      default: ;
    endcase
  endtask

  task automatic field_err(string f, logic [20:0] want, logic [20:0] got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, f, want, got);
    errors++;
  endtask

  always @(posedge clk_i) begin : monitor
    bit      emits;
    result_t guess;
    result_t want;
    if (rst_ni) begin
      quiet_cycles++;
      if (result_valid_o) begin
        quiet_cycles = 0;
        if (due_results.size() == 0) begin
          $display("%0t ns: result with no request pending, expected none, got %h",
                   $time, result_o);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (result_o.tick_time !== want.tick_time)
            field_err("tick_time", want.tick_time, result_o.tick_time);
          if (result_o.idle !== want.idle)
            field_err("idle", 21'(want.idle), 21'(result_o.idle));
          if (result_o.run_slot !== want.run_slot)
            field_err("run_slot", 21'(want.run_slot), 21'(result_o.run_slot));
          if (result_o.finished !== want.finished)
            field_err("finished", 21'(want.finished), 21'(result_o.finished));
          if (result_o.response_time !== want.response_time)
            field_err("response_time", want.response_time, result_o.response_time);
          if (result_o.waiting_time !== want.waiting_time)
            field_err("waiting_time", want.waiting_time, result_o.waiting_time);
          if (result_o.turnaround_time !== want.turnaround_time)
            field_err("turnaround_time", want.turnaround_time, result_o.turnaround_time);
          if (result_o.all_done !== want.all_done)
            field_err("all_done", 21'(want.all_done), 21'(result_o.all_done));
        end
      end
      if (cfg_we_i) begin
        quiet_cycles = 0;
        slot_count = cfg_wdata_i;
      end
      if (start_i && !busy_o) begin
        quiet_cycles = 0;
        sched_step(item_i, emits, guess);
        if (emits) due_results.push_back(pin_on ? pin_res : guess);
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // offers one request, idling in bursts; returns at the edge that takes it
  task automatic send(input item_t it, input bit pinned, input result_t want);
    if (burst_left == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    burst_left--;
    start_i <= 1'b1;
    item_i <= it;
    pin_on <= pinned;
    pin_res <= want;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (it.cmd != cmd_e'(CMD_UNUSED)) sent++;
  endtask

  task automatic set_count(input logic [4:0] v);
    start_i <= 1'b0;
    do @(negedge clk_i); while (due_results.size() != 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stim
    int    nact;
    int    ops;
    int    p;
    logic [4:0] cnt;
    logic [3:0] s;
    item_t it;

    // result layout: tick, idle, slot, finished, response, waiting, turnaround, all_done
    dir_tab.push_back('{1'b0, 5'd0, mk_req(CMD_TICK, 4'd0, 16'd0, 16'd0, 8'd0), 1'b1,
                        {21'd0, 1'b1, 4'd0, 1'b0, 21'd0, 21'd0, 21'd0, 1'b1}});
    dir_tab.push_back('{1'b0, 5'd0, mk_req(cmd_e'(CMD_UNUSED), 4'hF, 16'hFFFF, 16'hFFFF,
                        8'hFF), 1'b0, '0});
    dir_tab.push_back('{1'b0, 5'd0, mk_req(CMD_CLEAR, 4'hA, 16'h5A5A, 16'hA5A5, 8'h3C),
                        1'b0, '0});
    dir_tab.push_back('{1'b0, 5'd0, mk_req(CMD_LOAD, 4'd0, 16'd0, 16'd1, 8'd0), 1'b0, '0});
    dir_tab.push_back('{1'b0, 5'd0, mk_req(CMD_TICK, 4'd0, 16'd0, 16'd0, 8'd0), 1'b1,
                        {21'd0, 1'b0, 4'd0, 1'b1, 21'd0, 21'd0, 21'd1, 1'b1}});
    // zero burst: loaded already finished
    dir_tab.push_back('{1'b0, 5'd0, mk_req(CMD_LOAD, 4'd0, 16'd0, 16'd0, 8'hFF), 1'b0, '0});
    dir_tab.push_back('{1'b0, 5'd0, mk_req(CMD_TICK, 4'd0, 16'd0, 16'd0, 8'd0), 1'b1,
                        {21'd1, 1'b1, 4'd0, 1'b0, 21'd0, 21'd0, 21'd0, 1'b1}});
    dir_tab.push_back('{1'b1, 5'd16, '0, 1'b0, '0});
    dir_tab.push_back('{1'b0, 5'd0, mk_req(CMD_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 8'd0),
                        1'b0, '0});
    // equal orders, lower index wins; slot 5 arrives later and preempts
    dir_tab.push_back('{1'b0, 5'd0, mk_req(CMD_LOAD, 4'd3, 16'd0, 16'd2, 8'd200), 1'b0, '0});
    dir_tab.push_back('{1'b0, 5'd0, mk_req(CMD_LOAD, 4'd4, 16'd0, 16'd2, 8'd200), 1'b0, '0});
    dir_tab.push_back('{1'b0, 5'd0, mk_req(CMD_LOAD, 4'd5, 16'd3, 16'd1, 8'd7), 1'b0, '0});
    repeat (5)
      dir_tab.push_back('{1'b0, 5'd0, mk_req(CMD_TICK, 4'd0, 16'd0, 16'd0, 8'd0), 1'b0, '0});
    dir_tab.push_back('{1'b0, 5'd0, mk_req(CMD_LOAD, 4'd15, 16'd0, 16'd0, 8'd0), 1'b0, '0});
    // no active slot: idle and all done
    dir_tab.push_back('{1'b1, 5'd0, '0, 1'b0, '0});
    dir_tab.push_back('{1'b0, 5'd0, mk_req(CMD_TICK, 4'd0, 16'd0, 16'd0, 8'd0), 1'b1,
                        {21'd7, 1'b1, 4'd0, 1'b0, 21'd0, 21'd0, 21'd0, 1'b1}});
    // count above table size acts as full table
    dir_tab.push_back('{1'b1, 5'd31, '0, 1'b0, '0});
    dir_tab.push_back('{1'b0, 5'd0, mk_req(CMD_TICK, 4'd0, 16'd0, 16'd0, 8'd0), 1'b0, '0});
    dir_tab.push_back('{1'b1, 5'd1, '0, 1'b0, '0});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) set_count(dir_tab[i].cfg_val);
      else send(dir_tab[i].req, dir_tab[i].pinned, dir_tab[i].want);
    end

    sent = 0;
    while (sent < RAND_REQS) begin
      case ($urandom_range(0, 9))
        0: cnt = 5'd16;
        1: cnt = 5'($urandom_range(17, 31));
        2: cnt = ($urandom_range(0, 2) == 0) ? 5'd0 : 5'd1;
        default: cnt = 5'($urandom_range(1, 8));
      endcase
      set_count(cnt);
      nact = (cnt > 5'd16) ? 16 : int'(cnt);
      send(mk_req(CMD_CLEAR, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom)),
           1'b0, '0);
      for (int k = 0; k < nact; k++) send(fresh_proc(4'(k)), 1'b0, '0);
      ops = $urandom_range(8, 40);
      repeat (ops) begin
        p = $urandom_range(0, 99);
        s = (nact == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, nact - 1));
        if (p < 75)
          it = mk_req(CMD_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
        else if (p < 85)
          it = fresh_proc(s);
        else if (p < 90)
          it = mk_req(CMD_CLEAR, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
        else if (p < 93)
          it = mk_req(cmd_e'(CMD_UNUSED), 4'($urandom), 16'($urandom), 16'($urandom),
                      8'($urandom));
        else
          it = mk_req(CMD_LOAD, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
        send(it, 1'b0, '0);
      end
    end

    start_i <= 1'b0;
    do @(negedge clk_i); while (due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: tick_priority_process_scheduler.f
rtl/tpps_pkg.sv
rtl/tpps_ctrl.sv
rtl/tpps_dpath.sv
rtl/tick_priority_process_scheduler.sv
verif/tb_top.sv
